// ----- rtl/core/lpr_pkg.sv -----
// Shared types, constants and helper functions for the IPv4 longest-prefix route table.
`timescale 1ns / 1ps

package lpr_pkg;

    localparam int TABLE_SIZE = 64;
    localparam int IDX_W      = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
    localparam int CNT_W      = $clog2(TABLE_SIZE + 1);

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_DELETE = 2'd1;
    localparam logic [1:0] CMD_QUERY  = 2'd2;

    localparam logic [5:0] MAX_LEN = 6'd32;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_LAST   = 4'b0100,
        ST_COMMIT = 4'b1000
    } state_t;

    typedef struct packed {
        logic [31:0] prefix;
        logic [5:0]  length;
        logic [7:0]  port;
        logic [31:0] hop;
    } entry_t;

    typedef struct packed {
        logic exact;
        logic route;
    } lpr_hit_t;

    function automatic logic [31:0] swap_bytes(input logic [31:0] v);
        swap_bytes = {v[7:0], v[15:8], v[23:16], v[31:24]};
    endfunction

    function automatic logic [5:0] sat_len(input logic [5:0] len);
        sat_len = (len > MAX_LEN) ? MAX_LEN : len;
    endfunction

    // len must already be saturated to 32
    function automatic logic [31:0] len_mask(input logic [5:0] len);
        logic [5:0] sh;
        sh = MAX_LEN - len;
        if (len == 6'd0)
        begin
            len_mask = 32'd0;
        end
        else
        begin
            len_mask = 32'hFFFF_FFFF << sh;
        end
    endfunction

endpackage

// ----- rtl/core/lpr_match_unit.sv -----
// Shared compare unit: exact prefix/length match and route cover test for one slot.
`timescale 1ns / 1ps

module lpr_match_unit
    import lpr_pkg::*;
(
    input  logic [31:0] entry_prefix,
    input  logic [5:0]  entry_len,
    input  logic [31:0] key_addr,
    input  logic [31:0] key_prefix,
    input  logic [5:0]  key_len,
    output lpr_hit_t    hit
);

    logic [5:0] len_sat;

    assign len_sat   = sat_len(entry_len);
    assign hit.exact = (entry_prefix == key_prefix) && (entry_len == key_len);
    assign hit.route = (key_addr & len_mask(len_sat)) == entry_prefix;

endmodule

// ----- rtl/core/ipv4_longest_prefix_route_table.sv -----
// IPv4 longest-prefix route table: top level with scan sequencer and slot memory.
//
// Every transaction (insert, delete or query) reads the slot memory one slot
// per cycle over all 64 slots through the single shared compare unit, then
// takes ST_LAST for the last compare and ST_COMMIT, which writes the slot and
// loads the result register once any earlier result has been taken. in_ready is
// high only while the sequencer is idle; a finished result waits in its own
// output register, so the next transaction can be accepted before it is taken.
// Addresses arrive first octet in the low byte and are byte-swapped on entry.
// The slot valid bits clear at reset; slot contents need no clearing.
`timescale 1ns / 1ps

module ipv4_longest_prefix_route_table
    import lpr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  command,
    input  logic [31:0] address,
    input  logic [5:0]  prefix_len,
    input  logic [7:0]  port_index,
    input  logic [31:0] next_hop,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        found,
    output logic [31:0] match_nexthop,
    output logic [7:0]  match_port,
    output logic        status
);

    state_t state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             cmp_valid_reg, cmp_valid_next;
    logic [IDX_W-1:0] cmp_idx_reg, cmp_idx_next;

    logic [1:0]  cmd_reg, cmd_next;
    logic [31:0] key_addr_reg, key_addr_next;
    logic [31:0] key_prefix_reg, key_prefix_next;
    logic [5:0]  key_len_reg, key_len_next;
    logic [7:0]  port_reg, port_next;
    logic [31:0] hop_reg, hop_next;

    logic             hit_found_reg, hit_found_next;
    logic [IDX_W-1:0] hit_idx_reg, hit_idx_next;
    logic             free_found_reg, free_found_next;
    logic [IDX_W-1:0] free_idx_reg, free_idx_next;
    logic             best_found_reg, best_found_next;
    logic [5:0]       best_len_reg, best_len_next;
    logic [31:0]      best_hop_reg, best_hop_next;
    logic [7:0]       best_port_reg, best_port_next;

    logic [TABLE_SIZE-1:0] valid_reg, valid_next;

    logic        out_valid_reg, out_valid_next;
    logic        found_reg, found_next;
    logic [31:0] nexthop_reg, nexthop_next;
    logic [7:0]  mport_reg, mport_next;
    logic        status_reg, status_next;

    entry_t           slot_mem [TABLE_SIZE];
    entry_t           rd_data_reg;
    logic             rd_en;
    logic [IDX_W-1:0] rd_idx;
    logic             wr_en;
    logic [IDX_W-1:0] wr_idx;
    entry_t           wr_data;

    lpr_hit_t    hit;
    logic        entry_valid;
    logic        in_fire;
    logic        commit_fire;
    logic [31:0] in_addr_host;
    logic [5:0]  in_len_sat;

    assign in_ready     = (state_reg == ST_IDLE);
    assign in_fire      = in_valid && in_ready;
    assign commit_fire  = (state_reg == ST_COMMIT) && (!out_valid_reg || out_ready);
    assign in_addr_host = swap_bytes(address);
    assign in_len_sat   = sat_len(prefix_len);
    assign entry_valid  = valid_reg[cmp_idx_reg];

    assign rd_en  = (state_reg == ST_SCAN);
    assign rd_idx = cnt_reg[IDX_W-1:0];

    assign wr_data.prefix = key_prefix_reg;
    assign wr_data.length = key_len_reg;
    assign wr_data.port   = port_reg;
    assign wr_data.hop    = hop_reg;

    lpr_match_unit u_match (
        .entry_prefix (rd_data_reg.prefix),
        .entry_len    (rd_data_reg.length),
        .key_addr     (key_addr_reg),
        .key_prefix   (key_prefix_reg),
        .key_len      (key_len_reg),
        .hit          (hit)
    );

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_mem[wr_idx] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= slot_mem[rd_idx];
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        cmp_valid_next  = 1'b0;
        cmp_idx_next    = cmp_idx_reg;
        cmd_next        = cmd_reg;
        key_addr_next   = key_addr_reg;
        key_prefix_next = key_prefix_reg;
        key_len_next    = key_len_reg;
        port_next       = port_reg;
        hop_next        = hop_reg;
        hit_found_next  = hit_found_reg;
        hit_idx_next    = hit_idx_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        best_found_next = best_found_reg;
        best_len_next   = best_len_reg;
        best_hop_next   = best_hop_reg;
        best_port_next  = best_port_reg;
        valid_next      = valid_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        found_next      = found_reg;
        nexthop_next    = nexthop_reg;
        mport_next      = mport_reg;
        status_next     = status_reg;
        wr_en           = 1'b0;
        wr_idx          = hit_idx_reg;

        // compare stage, one slot per cycle
        if (cmp_valid_reg)
        begin
            if (entry_valid && hit.exact && !hit_found_reg)
            begin
                hit_found_next = 1'b1;
                hit_idx_next   = cmp_idx_reg;
            end
            if (!entry_valid && !free_found_reg)
            begin
                free_found_next = 1'b1;
                free_idx_next   = cmp_idx_reg;
            end
            if (entry_valid && hit.route &&
                (!best_found_reg || (sat_len(rd_data_reg.length) > best_len_reg)))
            begin
                best_found_next = 1'b1;
                best_len_next   = sat_len(rd_data_reg.length);
                best_hop_next   = rd_data_reg.hop;
                best_port_next  = rd_data_reg.port;
            end
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    cmd_next        = command;
                    key_addr_next   = in_addr_host;
                    key_len_next    = in_len_sat;
                    key_prefix_next = in_addr_host & len_mask(in_len_sat);
                    port_next       = port_index;
                    hop_next        = next_hop;
                    hit_found_next  = 1'b0;
                    free_found_next = 1'b0;
                    best_found_next = 1'b0;
                    best_len_next   = 6'd0;
                    cnt_next        = '0;
                    state_next      = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmp_valid_next = 1'b1;
                cmp_idx_next   = cnt_reg[IDX_W-1:0];
                cnt_next       = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(TABLE_SIZE - 1))
                begin
                    state_next = ST_LAST;
                end
            end
            ST_LAST:
            begin
                state_next = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                if (commit_fire)
                begin
                    out_valid_next = 1'b1;
                    found_next     = 1'b0;
                    nexthop_next   = 32'd0;
                    mport_next     = 8'd0;
                    status_next    = 1'b0;
                    case (cmd_reg)
                        CMD_INSERT:
                        begin
                            if (hit_found_reg)
                            begin
                                wr_en = 1'b1;
                            end
                            else if (free_found_reg)
                            begin
                                wr_en  = 1'b1;
                                wr_idx = free_idx_reg;
                            end
                            else
                            begin
                                status_next = 1'b1;
                            end
                            if (wr_en)
                            begin
                                valid_next[wr_idx] = 1'b1;
                            end
                        end
                        CMD_DELETE:
                        begin
                            if (hit_found_reg)
                            begin
                                valid_next[hit_idx_reg] = 1'b0;
                            end
                        end
                        CMD_QUERY:
                        begin
                            if (best_found_reg)
                            begin
                                found_next   = 1'b1;
                                nexthop_next = best_hop_reg;
                                mport_next   = best_port_reg;
                            end
                        end
                        default:
                        begin
                            found_next = 1'b0;
                        end
                    endcase
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            cmp_valid_reg <= 1'b0;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            cmp_valid_reg <= cmp_valid_next;
            valid_reg     <= valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmp_idx_reg    <= cmp_idx_next;
        cmd_reg        <= cmd_next;
        key_addr_reg   <= key_addr_next;
        key_prefix_reg <= key_prefix_next;
        key_len_reg    <= key_len_next;
        port_reg       <= port_next;
        hop_reg        <= hop_next;
        hit_found_reg  <= hit_found_next;
        hit_idx_reg    <= hit_idx_next;
        free_found_reg <= free_found_next;
        free_idx_reg   <= free_idx_next;
        best_found_reg <= best_found_next;
        best_len_reg   <= best_len_next;
        best_hop_reg   <= best_hop_next;
        best_port_reg  <= best_port_next;
        found_reg      <= found_next;
        nexthop_reg    <= nexthop_next;
        mport_reg      <= mport_next;
        status_reg     <= status_next;
    end

    assign out_valid     = out_valid_reg;
    assign found         = found_reg;
    assign match_nexthop = nexthop_reg;
    assign match_port    = mport_reg;
    assign status        = status_reg;

    // no compare may be pending while a new transaction can be taken
    assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !cmp_valid_reg)
        else $error("compare pending while idle");

    // a slot write only happens with a matching or free slot in hand
    assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (commit_fire && (hit_found_reg || free_found_reg)))
        else $error("slot write without a target slot");

    // a dropped insert never reports a route
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(status_reg && found_reg))
        else $error("result both full and found");

    // the scan closes cleanly: ST_LAST is followed by ST_COMMIT with no compare pending
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LAST) |=> (state_reg == ST_COMMIT) && !cmp_valid_reg)
        else $error("scan did not close cleanly");

endmodule

// ----- bench/ipv4_longest_prefix_route_table_tb.sv -----
`timescale 1ns / 1ps
// Testbench for the IPv4 route table: directed and random route commands checked against a predictor.

module ipv4_longest_prefix_route_table_tb;
    import lpr_pkg::*;

    localparam int RANDOM_CMDS  = 1580;
    localparam int POOL_MAX     = 96;
    localparam int LIMIT_CYCLES = 1_000_000;
    localparam int TAIL_CYCLES  = 150;

    localparam logic [1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] addr;
        logic [5:0]  len;
        logic [7:0]  port;
        logic [31:0] hop;
    } route_cmd_t;

    typedef struct packed {
        logic        hit;
        logic [31:0] hop;
        logic [7:0]  port;
        logic        full;
    } route_answer_t;

    typedef struct packed {
        logic [31:0] prefix;
        logic [5:0]  len;
    } route_key_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  command = CMD_INSERT;
    logic [31:0] address = 32'd0;
    logic [5:0]  prefix_len = 6'd0;
    logic [7:0]  port_index = 8'd0;
    logic [31:0] next_hop = 32'd0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        found;
    logic [31:0] match_nexthop;
    logic [7:0]  match_port;
    logic        status;

    route_cmd_t    pending_cmds[$];
    route_answer_t pending_answers[$];
    route_key_t    route_pool[$];
    route_cmd_t    on_wire;

    // predictor copy of the table
    logic        tbl_valid[TABLE_SIZE];
    logic [31:0] tbl_prefix[TABLE_SIZE];
    logic [5:0]  tbl_len[TABLE_SIZE];
    logic [7:0]  tbl_port[TABLE_SIZE];
    logic [31:0] tbl_hop[TABLE_SIZE];

    int total_cmds = 1;
    int sent_count = 0;
    int errors = 0;
    int cycles = 0;
    int n_insert = 0, n_full = 0, n_delete = 0, n_removed = 0;
    int n_query = 0, n_hit = 0, n_other = 0;

    ipv4_longest_prefix_route_table dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .command       (command),
        .address       (address),
        .prefix_len    (prefix_len),
        .port_index    (port_index),
        .next_hop      (next_hop),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .found         (found),
        .match_nexthop (match_nexthop),
        .match_port    (match_port),
        .status        (status)
    );

    always #10 clk = ~clk;

    function automatic logic [31:0] octet_swap(input logic [31:0] v);
        logic [31:0] r;
        for (int b = 0; b < 4; b++)
        begin
            r[8*b +: 8] = v[8*(3-b) +: 8];
        end
        return r;
    endfunction

    // lengths above 32 act as 32
    function automatic logic [31:0] prefix_mask(input logic [5:0] len);
        if (len >= 6'd32)
        begin
            return 32'hFFFF_FFFF;
        end
        return ~(32'hFFFF_FFFF >> len);
    endfunction

    function automatic route_answer_t apply_command(input route_cmd_t c);
        route_answer_t ans;
        logic [31:0]   host;
        logic [31:0]   key;
        logic [5:0]    l;
        logic [5:0]    best_len;
        int            hit;
        ans = '0;
        host = octet_swap(c.addr);
        l = (c.len > 6'd32) ? 6'd32 : c.len;
        key = host & prefix_mask(l);
        hit = -1;
        best_len = 6'd0;
        case (c.cmd)
            CMD_INSERT:
            begin
                n_insert++;
                for (int i = 0; i < TABLE_SIZE; i++)
                begin
                    if (hit < 0 && tbl_valid[i] && tbl_prefix[i] == key && tbl_len[i] == l)
                        hit = i;
                end
                for (int i = 0; i < TABLE_SIZE; i++)
                begin
                    if (hit < 0 && !tbl_valid[i])
                        hit = i;
                end
                if (hit < 0)
                begin
                    ans.full = 1'b1;
                    n_full++;
                end
                else
                begin
                    tbl_valid[hit]  = 1'b1;
                    tbl_prefix[hit] = key;
                    tbl_len[hit]    = l;
                    tbl_port[hit]   = c.port;
                    tbl_hop[hit]    = c.hop;
                end
            end
            CMD_DELETE:
            begin
                n_delete++;
                for (int i = 0; i < TABLE_SIZE; i++)
                begin
                    if (hit < 0 && tbl_valid[i] && tbl_prefix[i] == key && tbl_len[i] == l)
                        hit = i;
                end
                if (hit >= 0)
                begin
                    tbl_valid[hit] = 1'b0;
                    n_removed++;
                end
            end
            CMD_QUERY:
            begin
                n_query++;
                for (int i = 0; i < TABLE_SIZE; i++)
                begin
                    if (tbl_valid[i] && (host & prefix_mask(tbl_len[i])) == tbl_prefix[i]
                        && (hit < 0 || tbl_len[i] > best_len))
                    begin
                        hit = i;
                        best_len = tbl_len[i];
                    end
                end
                if (hit >= 0)
                begin
                    ans.hit  = 1'b1;
                    ans.hop  = tbl_hop[hit];
                    ans.port = tbl_port[hit];
                    n_hit++;
                end
            end
            default:
            begin
                n_other++;
            end
        endcase
        return ans;
    endfunction

    function automatic int idle_pct(input bit for_sender);
        int phase;
        phase = (sent_count * 3) / total_cmds;
        if (phase == 0)
            return for_sender ? 31 : 73;
        if (phase == 1)
            return for_sender ? 73 : 31;
        return 0;
    endfunction

    function automatic logic [5:0] random_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)
            return 6'd0;
        if (r < 15)
            return 6'($urandom_range(33, 63));
        return 6'($urandom_range(1, 32));
    endfunction

    function automatic logic [31:0] with_host_bits(input route_key_t k);
        return k.prefix | ($urandom & ~prefix_mask(k.len));
    endfunction

    // host is in host order; it goes on the wire first octet low
    task automatic push_cmd(input logic [1:0] cmd, input logic [31:0] host,
                            input logic [5:0] len, input logic [7:0] port,
                            input logic [31:0] hop);
        route_cmd_t c;
        c.cmd  = cmd;
        c.addr = octet_swap(host);
        c.len  = len;
        c.port = port;
        c.hop  = hop;
        pending_cmds.push_back(c);
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                pending_answers.push_back(apply_command(on_wire));
                sent_count++;
            end
            if (!in_valid || in_ready)
            begin
                if (pending_cmds.size() > 0 && $urandom_range(0, 99) >= idle_pct(1'b1))
                begin
                    on_wire = pending_cmds.pop_front();
                    command    <= on_wire.cmd;
                    address    <= on_wire.addr;
                    prefix_len <= on_wire.len;
                    port_index <= on_wire.port;
                    next_hop   <= on_wire.hop;
                    in_valid   <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        route_answer_t exp;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (pending_answers.size() == 0)
                begin
                    $error("result transaction with no command outstanding");
                    errors++;
                end
                else
                begin
                    exp = pending_answers.pop_front();
                    if (found !== exp.hit)
                    begin
                        $error("found: expected %0d, got %0d", exp.hit, found);
                        errors++;
                    end
                    if (match_nexthop !== exp.hop)
                    begin
                        $error("match_nexthop: expected %h, got %h", exp.hop, match_nexthop);
                        errors++;
                    end
                    if (match_port !== exp.port)
                    begin
                        $error("match_port: expected %h, got %h", exp.port, match_port);
                        errors++;
                    end
                    if (status !== exp.full)
                    begin
                        $error("status: expected %0d, got %0d", exp.full, status);
                        errors++;
                    end
                end
            end
            out_ready <= ($urandom_range(0, 99) >= idle_pct(1'b0));
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, pending_answers.size());
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        route_key_t  key;
        logic [31:0] host;
        logic [5:0]  len;
        int          roll;
        int          ins_w;
        int          del_w;

        for (int i = 0; i < TABLE_SIZE; i++)
        begin
            tbl_valid[i]  = 1'b0;
            tbl_prefix[i] = 32'd0;
            tbl_len[i]    = 6'd0;
            tbl_port[i]   = 8'd0;
            tbl_hop[i]    = 32'd0;
        end

        // directed: nesting, replace, saturation, head delete, misses, unused code
        push_cmd(CMD_QUERY,  32'h0A01_0203, 6'd0,  8'h00, 32'h0000_0000);
        push_cmd(CMD_INSERT, 32'h0000_0000, 6'd0,  8'hFF, 32'h0000_0000);
        push_cmd(CMD_INSERT, 32'h0AFF_FFFF, 6'd8,  8'h01, 32'hFFFF_FFFF);
        push_cmd(CMD_INSERT, 32'h0A01_ABCD, 6'd16, 8'h02, 32'hC0A8_0001);
        push_cmd(CMD_INSERT, 32'h0A01_0203, 6'd63, 8'h03, 32'h0A0A_0A0A);
        push_cmd(CMD_QUERY,  32'h0A01_0203, 6'd0,  8'h00, 32'h0000_0000);
        push_cmd(CMD_QUERY,  32'h0A01_0909, 6'd0,  8'h00, 32'h0000_0000);
        push_cmd(CMD_QUERY,  32'h0A09_0909, 6'd0,  8'h00, 32'h0000_0000);
        push_cmd(CMD_QUERY,  32'h0B00_0000, 6'd0,  8'h00, 32'h0000_0000);
        push_cmd(CMD_INSERT, 32'h0A00_0000, 6'd8,  8'h04, 32'h1234_5678);
        push_cmd(CMD_QUERY,  32'h0A09_0909, 6'd0,  8'h00, 32'h0000_0000);
        push_cmd(CMD_DELETE, 32'h0A01_FFFF, 6'd16, 8'h00, 32'h0000_0000);
        push_cmd(CMD_QUERY,  32'h0A01_0909, 6'd0,  8'h00, 32'h0000_0000);
        push_cmd(CMD_DELETE, 32'h0A01_0203, 6'd40, 8'h00, 32'h0000_0000);
        push_cmd(CMD_QUERY,  32'h0A01_0203, 6'd0,  8'h00, 32'h0000_0000);
        push_cmd(CMD_DELETE, 32'hC0A8_0000, 6'd24, 8'h00, 32'h0000_0000);
        push_cmd(CMD_DELETE, 32'h0000_0000, 6'd0,  8'h00, 32'h0000_0000);
        push_cmd(CMD_QUERY,  32'h0B00_0000, 6'd0,  8'h00, 32'h0000_0000);
        push_cmd(CMD_UNUSED, 32'hFFFF_FFFF, 6'h3F, 8'hFF, 32'hFFFF_FFFF);
        push_cmd(CMD_INSERT, 32'hFFFF_FFFF, 6'd32, 8'h00, 32'h0000_0000);
        push_cmd(CMD_QUERY,  32'hFFFF_FFFF, 6'd0,  8'h00, 32'h0000_0000);
        push_cmd(CMD_QUERY,  32'h0A00_0001, 6'h3F, 8'hFF, 32'hFFFF_FFFF);

        // random: alternate fill-heavy and drain-heavy stretches over a pool of routes
        for (int k = 0; k < RANDOM_CMDS; k++)
        begin
            ins_w = (((k / 200) % 2) == 0) ? 50 : 15;
            del_w = (((k / 200) % 2) == 0) ? 10 : 40;
            roll = $urandom_range(0, 99);
            if (roll < ins_w)
            begin
                if (route_pool.size() > 0 && $urandom_range(0, 99) < 40)
                begin
                    key = route_pool[$urandom_range(0, route_pool.size() - 1)];
                    host = with_host_bits(key);
                    len = key.len;
                end
                else
                begin
                    host = $urandom;
                    len = random_len();
                    key.prefix = host & prefix_mask(len);
                    key.len = len;
                    if (route_pool.size() < POOL_MAX)
                        route_pool.push_back(key);
                    else
                        route_pool[$urandom_range(0, POOL_MAX - 1)] = key;
                end
                push_cmd(CMD_INSERT, host, len, 8'($urandom), $urandom);
            end
            else if (roll < ins_w + del_w)
            begin
                if (route_pool.size() > 0 && $urandom_range(0, 99) < 75)
                begin
                    key = route_pool[$urandom_range(0, route_pool.size() - 1)];
                    push_cmd(CMD_DELETE, with_host_bits(key), key.len,
                             8'($urandom), $urandom);
                end
                else
                begin
                    push_cmd(CMD_DELETE, $urandom, random_len(), 8'($urandom), $urandom);
                end
            end
            else if (roll < 95)
            begin
                if (route_pool.size() > 0 && $urandom_range(0, 99) < 80)
                begin
                    key = route_pool[$urandom_range(0, route_pool.size() - 1)];
                    host = with_host_bits(key);
                end
                else
                begin
                    host = $urandom;
                end
                push_cmd(CMD_QUERY, host, 6'($urandom), 8'($urandom), $urandom);
            end
            else
            begin
                push_cmd(CMD_UNUSED, $urandom, 6'($urandom), 8'($urandom), $urandom);
            end
        end
        total_cmds = pending_cmds.size();

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_cmds.size() > 0 || in_valid || pending_answers.size() > 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("ran %0d transactions: %0d inserts (%0d dropped on full table), %0d deletes",
                 sent_count, n_insert, n_full, n_delete);
        $display("(%0d removed), %0d queries (%0d matched), %0d unused codes; %0d mismatches",
                 n_removed, n_query, n_hit, n_other, errors);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/core/lpr_pkg.sv
rtl/core/lpr_match_unit.sv
rtl/core/ipv4_longest_prefix_route_table.sv
bench/ipv4_longest_prefix_route_table_tb.sv
